### design/netm_pkg.sv
package netm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ADDR_W      = 64;
    localparam int MAC_W       = 48;
    localparam int COUNT_OUT_W = 7;
    localparam int LIMIT_W     = 7;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int V4_W        = 32;

    // register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_ENTRY_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 7'd64;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DEL    = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t               op;
        logic              is_ipv6;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [MAC_W-1:0]  mac_in;
    } req_t;

    typedef struct packed {
        logic                   status;
        logic                   hit;
        logic [MAC_W-1:0]       mac_out;
        logic [COUNT_OUT_W-1:0] count_out;
    } rsp_t;

    // search key, broadcast to every cell
    typedef struct packed {
        logic              is_ipv6;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
    } key_t;

    // token walking down the chain, one cell per cycle
    typedef struct packed {
        logic             active;
        logic             hit;
        logic [MAC_W-1:0] mac;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } tok_t;

    // broadcast commands from the controller to the cells
    typedef struct packed {
        logic             clr;
        logic             del_en;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [MAC_W-1:0] wr_mac;
    } cell_cmd_t;

endpackage

### design/netm_cell.sv
module netm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [netm_pkg::IDX_W-1:0]    slot_idx,
    input  netm_pkg::key_t                key,
    input  netm_pkg::cell_cmd_t           cmd,
    input  netm_pkg::tok_t                tok_in,
    output netm_pkg::tok_t                tok_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          fam_reg;
    logic [netm_pkg::ADDR_W-1:0]   hi_reg;
    logic [netm_pkg::ADDR_W-1:0]   lo_reg;
    logic [netm_pkg::MAC_W-1:0]    mac_reg;
    netm_pkg::tok_t                tok_reg;
    netm_pkg::tok_t                tok_next;
    logic                          match;
    logic                          wr_sel;

    assign wr_sel = cmd.wr_en && (cmd.wr_idx == slot_idx);

    // IPv4 compares only the upper word of addr_high
    always_comb
    begin
        match = 1'b0;
        if (valid_reg && (fam_reg == key.is_ipv6))
        begin
            if (key.is_ipv6)
                match = (hi_reg == key.addr_high) && (lo_reg == key.addr_low);
            else
                match = hi_reg[netm_pkg::ADDR_W-1 -: netm_pkg::V4_W] ==
                        key.addr_high[netm_pkg::ADDR_W-1 -: netm_pkg::V4_W];
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active)
        begin
            if (match)
            begin
                tok_next.hit = 1'b1;
                tok_next.mac = mac_reg;
            end
            if (!tok_in.free_found && !valid_reg)
            begin
                tok_next.free_found = 1'b1;
                tok_next.free_idx   = slot_idx;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        priority if (cmd.clr)
            valid_next = 1'b0;
        else if (wr_sel)
            valid_next = 1'b1;
        else if (cmd.del_en && tok_in.active && match)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            fam_reg <= key.is_ipv6;
            hi_reg  <= key.addr_high;
            lo_reg  <= key.addr_low;
            mac_reg <= cmd.wr_mac;
        end
    end

    assign tok_out = tok_reg;

endmodule

### design/netm_ctrl.sv
module netm_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  netm_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output netm_pkg::rsp_t                  rsp,
    input  logic [netm_pkg::LIMIT_W-1:0]    entry_limit,
    output netm_pkg::key_t                  key,
    output netm_pkg::cell_cmd_t             cmd,
    output netm_pkg::tok_t                  tok_head,
    input  netm_pkg::tok_t                  tok_tail
);

    netm_pkg::state_t              state_reg;
    netm_pkg::state_t              state_next;
    netm_pkg::op_t                 op_reg;
    netm_pkg::op_t                 op_next;
    netm_pkg::key_t                key_reg;
    netm_pkg::key_t                key_next;
    logic [netm_pkg::MAC_W-1:0]    mac_in_reg;
    logic [netm_pkg::MAC_W-1:0]    mac_in_next;
    netm_pkg::tok_t                res_reg;
    netm_pkg::tok_t                res_next;
    netm_pkg::tok_t                inj_reg;
    netm_pkg::tok_t                inj_next;
    logic [netm_pkg::CNT_W-1:0]    count_reg;
    logic [netm_pkg::CNT_W-1:0]    count_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    netm_pkg::rsp_t                rsp_reg;
    netm_pkg::rsp_t                rsp_next;

    logic accept;
    logic out_free;
    logic commit;
    logic full;
    logic is_add_miss;
    logic do_write;

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign commit   = (state_reg == netm_pkg::ST_FINISH) && out_free;

    assign full = (netm_pkg::CMP_W'(count_reg) >= netm_pkg::CMP_W'(entry_limit)) ||
                  (netm_pkg::CMP_W'(count_reg) >= netm_pkg::CMP_W'(netm_pkg::TABLE_DEPTH));
    assign is_add_miss = (op_reg == netm_pkg::OP_ADD) && !res_reg.hit;
    assign do_write    = is_add_miss && !full && res_reg.free_found;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            netm_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = (req.op == netm_pkg::OP_FLUSH) ? netm_pkg::ST_FINISH
                                                                : netm_pkg::ST_SCAN;
            end
            netm_pkg::ST_SCAN:
            begin
                if (tok_tail.active)
                    state_next = netm_pkg::ST_FINISH;
            end
            netm_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = netm_pkg::ST_IDLE;
            end
            default:
                state_next = netm_pkg::ST_IDLE;
        endcase
    end

    // outputs toward the cells and the request side
    always_comb
    begin
        req_stall  = (state_reg != netm_pkg::ST_IDLE);
        cmd        = '0;
        cmd.wr_idx = res_reg.free_idx;
        cmd.wr_mac = mac_in_reg;
        unique case (state_reg)
            netm_pkg::ST_IDLE:
                cmd.del_en = 1'b0;
            netm_pkg::ST_SCAN:
                cmd.del_en = (op_reg == netm_pkg::OP_DEL);
            netm_pkg::ST_FINISH:
            begin
                cmd.clr   = commit && (op_reg == netm_pkg::OP_FLUSH);
                cmd.wr_en = commit && do_write;
            end
            default:
                cmd.del_en = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        mac_in_next    = mac_in_reg;
        res_next       = res_reg;
        inj_next       = '0;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        if (accept)
        begin
            op_next            = req.op;
            key_next.is_ipv6   = req.is_ipv6;
            key_next.addr_high = req.addr_high;
            key_next.addr_low  = req.addr_low;
            mac_in_next        = req.mac_in;
            inj_next.active    = (req.op != netm_pkg::OP_FLUSH);
        end

        if ((state_reg == netm_pkg::ST_SCAN) && tok_tail.active)
            res_next = tok_tail;

        if (commit)
        begin
            unique case (op_reg)
                netm_pkg::OP_FLUSH:
                    count_next = '0;
                netm_pkg::OP_ADD:
                begin
                    if (do_write)
                        count_next = count_reg + netm_pkg::CNT_W'(1);
                end
                netm_pkg::OP_DEL:
                begin
                    if (res_reg.hit && (count_reg != '0))
                        count_next = count_reg - netm_pkg::CNT_W'(1);
                end
                netm_pkg::OP_LOOKUP:
                    count_next = count_reg;
                default:
                    count_next = count_reg;
            endcase
            rsp_valid_next     = 1'b1;
            rsp_next.status    = is_add_miss && (full || !res_reg.free_found);
            rsp_next.hit       = (op_reg != netm_pkg::OP_FLUSH) && res_reg.hit;
            rsp_next.mac_out   = ((op_reg == netm_pkg::OP_LOOKUP) && res_reg.hit) ?
                                 res_reg.mac : '0;
            rsp_next.count_out = netm_pkg::COUNT_OUT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= netm_pkg::ST_IDLE;
            inj_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_reg       <= inj_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        mac_in_reg <= mac_in_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign key       = key_reg;
    assign tok_head  = inj_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### design/neighbor_exact_match_table.sv
// Channel   Dir  Handshake           Word
// req       in   req_valid/stall     op, is_ipv6, addr_high, addr_low, mac_in
// rsp       out  rsp_valid/stall     status, hit, mac_out, count_out
// apb       in   psel/penable/pready entry_limit at byte address 0
//
// Lookup, add and delete run to completion before the next accept: the search
// token walks the row of cells one slot per cycle. Flush skips the scan.
// Reset clears every slot valid bit and the entry count at once; entry_limit
// resets to 64.
// A new request word is taken while the previous response still waits; a
// finished search holds until the response register is free.

module neighbor_exact_match_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  netm_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output netm_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [netm_pkg::PADDR_W-1:0]  paddr,
    input  logic [netm_pkg::PDATA_W-1:0]  pwdata,
    output logic [netm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [netm_pkg::LIMIT_W-1:0] limit_reg;
    logic                         limit_wr;
    netm_pkg::key_t               key;
    netm_pkg::cell_cmd_t          cmd;
    netm_pkg::tok_t               chain [netm_pkg::TABLE_DEPTH+1];

    // Register port: single register, no wait states.
    assign pready   = 1'b1;
    assign limit_wr = psel && penable && pwrite && pready &&
                      (paddr[netm_pkg::PADDR_W-1:2] == netm_pkg::REG_ENTRY_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= netm_pkg::LIMIT_RESET;
        else if (limit_wr)
            limit_reg <= pwdata[netm_pkg::LIMIT_W-1:0];
    end

    always_comb
    begin
        if (paddr[netm_pkg::PADDR_W-1:2] == netm_pkg::REG_ENTRY_LIMIT)
            prdata = netm_pkg::PDATA_W'(limit_reg);
        else
            prdata = '0;
    end

    // Controller: latches the request, injects the search token at the head
    // of the chain, collects it at the tail and commits add/flush/count.
    netm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .entry_limit (limit_reg),
        .key         (key),
        .cmd         (cmd),
        .tok_head    (chain[0]),
        .tok_tail    (chain[netm_pkg::TABLE_DEPTH])
    );

    // One cell per slot. The token picks up hit, MAC and the lowest free
    // slot as it passes; deletes clear the matching slot on the way.
    for (genvar g = 0; g < netm_pkg::TABLE_DEPTH; g++)
    begin : g_cell
        netm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_idx (netm_pkg::IDX_W'(g)),
            .key      (key),
            .cmd      (cmd),
            .tok_in   (chain[g]),
            .tok_out  (chain[g+1])
        );
    end

endmodule

### design/netm_checker.sv
module netm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input netm_pkg::rsp_t rsp
);

    // a held response word stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one request in flight: stall right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted back to back");

    // full is only reported for a new key
    a_full_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.status && rsp.hit))
        else $error("full status on a hit");

    // MAC only comes back from a hit
    a_mac_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.mac_out != '0) |-> rsp.hit)
        else $error("MAC returned without hit");

    // count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count_out <= netm_pkg::COUNT_OUT_W'(netm_pkg::TABLE_DEPTH)))
        else $error("entry count out of range");

endmodule

bind neighbor_exact_match_table netm_checker u_netm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### sim/neighbor_exact_match_table_test.sv
module neighbor_exact_match_table_test;
    import netm_pkg::*;

    localparam int PERIOD      = 20;
    localparam int STALL_LIMIT = 2000;   // cycles with no word moving on either channel
    localparam int POOL_SIZE   = 96;     // more keys than slots, so the table can fill
    localparam int PRINT_MAX   = 50;
    localparam int LIMIT_MAX   = (1 << LIMIT_W) - 1;

    // register map: entry_limit at byte 0, the next word is unmapped
    localparam logic [PADDR_W-1:0] ADDR_LIMIT = {REG_ENTRY_LIMIT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_ENTRY_LIMIT, 2'b00};

    localparam logic [ADDR_W-1:0] ALL_ONES = '1;
    localparam logic [MAC_W-1:0]  MAC_ONES = '1;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_stall;
    rsp_t                rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    neighbor_exact_match_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the neighbor table. Updated in accept order, which is
    // also the order the block executes operations, so each accepted request
    // word yields exactly one expected response word.
    // ------------------------------------------------------------------
    logic               nb_used [TABLE_DEPTH];
    logic               nb_v6   [TABLE_DEPTH];
    logic [ADDR_W-1:0]  nb_hi   [TABLE_DEPTH];
    logic [ADDR_W-1:0]  nb_lo   [TABLE_DEPTH];
    logic [MAC_W-1:0]   nb_mac  [TABLE_DEPTH];
    int                 nb_count;
    logic [LIMIT_W-1:0] cfg_limit;

    rsp_t expected_rsp[$];

    // key pool for the random phases
    logic              pool_v6 [POOL_SIZE];
    logic [ADDR_W-1:0] pool_hi [POOL_SIZE];
    logic [ADDR_W-1:0] pool_lo [POOL_SIZE];

    int errors      = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;   // set for a stretch with no idling on either side

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < PRINT_MAX)
            $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Lowest slot holding the same family and address, TABLE_DEPTH if none.
    // IPv4 compares only addr_high[63:32].
    function automatic int find_neighbor(input logic v6, input logic [ADDR_W-1:0] hi,
                                         input logic [ADDR_W-1:0] lo);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (nb_used[i] && nb_v6[i] == v6)
            begin
                if (v6 ? (nb_hi[i] == hi && nb_lo[i] == lo)
                       : (nb_hi[i][ADDR_W-1:ADDR_W-V4_W] == hi[ADDR_W-1:ADDR_W-V4_W]))
                    return i;
            end
        end
        return TABLE_DEPTH;
    endfunction

    // Apply one operation to the shadow table and return the response it gives.
    function automatic rsp_t apply_op(input req_t w);
        rsp_t r;
        int   slot;
        int   free_slot;
        r = '0;
        if (w.op == OP_FLUSH)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                nb_used[i] = 1'b0;
            nb_count = 0;
        end
        else
        begin
            slot  = find_neighbor(w.is_ipv6, w.addr_high, w.addr_low);
            r.hit = (slot < TABLE_DEPTH);
            case (w.op)
                OP_LOOKUP:
                    if (r.hit)
                        r.mac_out = nb_mac[slot];
                OP_ADD:
                    // existing key: no MAC update; otherwise full check, then lowest free slot
                    if (!r.hit)
                    begin
                        if (nb_count >= int'(cfg_limit) || nb_count >= TABLE_DEPTH)
                            r.status = 1'b1;
                        else
                        begin
                            free_slot = 0;
                            while (nb_used[free_slot])
                                free_slot++;
                            nb_used[free_slot] = 1'b1;
                            nb_v6[free_slot]   = w.is_ipv6;
                            nb_hi[free_slot]   = w.addr_high;
                            nb_lo[free_slot]   = w.addr_low;
                            nb_mac[free_slot]  = w.mac_in;
                            nb_count++;
                        end
                    end
                OP_DEL:
                    if (r.hit)
                    begin
                        nb_used[slot] = 1'b0;
                        nb_count--;
                    end
                default: ;
            endcase
        end
        r.count_out = nb_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic req_t make_word(input op_t op, input logic v6,
                                       input logic [ADDR_W-1:0] hi,
                                       input logic [ADDR_W-1:0] lo,
                                       input logic [MAC_W-1:0] mac);
        req_t w;
        w.op        = op;
        w.is_ipv6   = v6;
        w.addr_high = hi;
        w.addr_low  = lo;
        w.mac_in    = mac;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random op on a pool key. Some keys are near misses (one address bit
    // flipped) and some are pure noise. IPv4 don't-care bits are always
    // scrambled so the compare mask gets exercised.
    function automatic req_t random_word(input int add_pct, input int del_pct,
                                         input int flush_pct);
        req_t        w;
        int          k;
        int          roll;
        int          pos;
        logic [63:0] tmp;
        roll = $urandom_range(99);
        if (roll < flush_pct)
            w.op = OP_FLUSH;
        else if (roll < flush_pct + add_pct)
            w.op = OP_ADD;
        else if (roll < flush_pct + add_pct + del_pct)
            w.op = OP_DEL;
        else
            w.op = OP_LOOKUP;
        k           = $urandom_range(POOL_SIZE - 1);
        w.is_ipv6   = pool_v6[k];
        w.addr_high = pool_hi[k];
        w.addr_low  = pool_lo[k];
        roll        = $urandom_range(99);
        if (roll < 8)
        begin
            w.is_ipv6   = 1'($urandom_range(1));
            w.addr_high = rand64();
            w.addr_low  = rand64();
        end
        else if (roll < 16)
        begin
            if (w.is_ipv6)
            begin
                pos = $urandom_range(2 * ADDR_W - 1);
                if (pos < ADDR_W)
                    w.addr_low[pos] = ~w.addr_low[pos];
                else
                    w.addr_high[pos - ADDR_W] = ~w.addr_high[pos - ADDR_W];
            end
            else
            begin
                pos = $urandom_range(ADDR_W - 1, ADDR_W - V4_W);
                w.addr_high[pos] = ~w.addr_high[pos];
            end
        end
        if (!w.is_ipv6)
        begin
            w.addr_high[ADDR_W-V4_W-1:0] = $urandom;
            w.addr_low                   = rand64();
        end
        tmp      = rand64();
        w.mac_in = tmp[MAC_W-1:0];
        return w;
    endfunction

    // Sends one request word. valid stays high after the accept so the next
    // call can follow back to back; callers that pause go through wait_idle.
    task automatic send_word(input req_t w);
        if (!quiet && $urandom_range(99) < 30)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 2 * TABLE_DEPTH)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp.push_back(apply_op(w));
    endtask

    // Drop valid and hold off until every response is back. One response per
    // request, so the block is idle once the queue is empty.
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // APB write, then read back the same address. Only entry_limit is mapped;
    // its read value is checked, the spare address is just poked.
    task automatic reg_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (a == ADDR_LIMIT)
            cfg_limit = d[LIMIT_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (a == ADDR_LIMIT && prdata[LIMIT_W-1:0] !== cfg_limit)
            report_mismatch("entry_limit readback", 64'(prdata), 64'(cfg_limit));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // ---- directed: every op, family and mask handling, duplicate add ----
    task automatic test_basic_ops();
        send_word(make_word(OP_LOOKUP, 1'b0, '0, '0, MAC_ONES));            // empty table
        send_word(make_word(OP_ADD,    1'b0, ALL_ONES, ALL_ONES, MAC_ONES));
        // low half of addr_high and all of addr_low are don't-care for IPv4
        send_word(make_word(OP_LOOKUP, 1'b0, {32'hFFFF_FFFF, 32'h0}, '0, '0));
        // same bits as IPv6: different family, must miss
        send_word(make_word(OP_LOOKUP, 1'b1, ALL_ONES, ALL_ONES, '0));
        // duplicate add keeps the old MAC
        send_word(make_word(OP_ADD,    1'b0, ALL_ONES, '0, '0));
        send_word(make_word(OP_LOOKUP, 1'b0, ALL_ONES, '0, '0));
        send_word(make_word(OP_ADD,    1'b1, '0, '0, 48'h0123_4567_89AB));
        send_word(make_word(OP_LOOKUP, 1'b1, '0, '0, '0));
        send_word(make_word(OP_LOOKUP, 1'b1, '0, 64'h1, '0));              // one bit off
        send_word(make_word(OP_LOOKUP, 1'b0, '0, '0, '0));                 // wrong family
        send_word(make_word(OP_DEL,    1'b1, '0, 64'h8000_0000_0000_0000, '0));
        send_word(make_word(OP_DEL,    1'b0, {32'hFFFF_FFFF, 32'h1234_5678}, ALL_ONES, '0));
        send_word(make_word(OP_LOOKUP, 1'b0, ALL_ONES, ALL_ONES, '0));
        send_word(make_word(OP_DEL,    1'b0, ALL_ONES, ALL_ONES, '0));     // already gone
        send_word(make_word(OP_ADD,    1'b0, 64'h1234_5678_0000_0000, '0, 48'h0000_0000_0001));
        send_word(make_word(OP_FLUSH,  1'b0, '0, '0, '0));
        send_word(make_word(OP_LOOKUP, 1'b1, '0, '0, '0));
        send_word(make_word(OP_DEL,    1'b0, 64'h1234_5678_0000_0000, '0, '0));
    endtask

    // ---- directed: full status, limit changes, unmapped register ----
    task automatic test_entry_limit();
        wait_idle();
        reg_write(ADDR_LIMIT, '0);
        send_word(make_word(OP_ADD, 1'b0, 64'hA000_0000_0000_0000, '0, 48'hA));
        wait_idle();
        reg_write(ADDR_LIMIT, 32'd2);
        send_word(make_word(OP_ADD, 1'b0, 64'hA000_0000_0000_0000, '0, 48'hA));
        send_word(make_word(OP_ADD, 1'b1, 64'hB, 64'hB, 48'hB));
        send_word(make_word(OP_ADD, 1'b1, 64'hC, 64'hC, 48'hC));            // full
        send_word(make_word(OP_ADD, 1'b0, 64'hA000_0000_FFFF_FFFF, '0, '0)); // exists at limit
        wait_idle();
        // limit below the current count
        reg_write(ADDR_LIMIT, 32'd1);
        send_word(make_word(OP_ADD, 1'b1, 64'hC, 64'hC, 48'hC));
        send_word(make_word(OP_DEL, 1'b0, 64'hA000_0000_0000_0000, '0, '0));
        wait_idle();
        // unmapped address must leave the limit alone
        reg_write(ADDR_SPARE, 32'd64);
        send_word(make_word(OP_ADD, 1'b1, 64'hC, 64'hC, 48'hC));
        wait_idle();
        // only the low 7 bits of the write land
        reg_write(ADDR_LIMIT, 32'hFFFF_FF83);
        send_word(make_word(OP_ADD, 1'b1, 64'hC, 64'hC, 48'hC));
        send_word(make_word(OP_FLUSH, 1'b0, '0, '0, '0));
    endtask

    // Shared random loop; pauses halfway until all responses are back.
    task automatic run_random(input int count, input int add_pct, input int del_pct,
                              input int flush_pct);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_idle();
            send_word(random_word(add_pct, del_pct, flush_pct));
        end
    endtask

    // limit above depth, add-heavy: the table runs into TABLE_DEPTH itself.
    // Whole phase runs with no random idling on either side, apart from the pause halfway.
    task automatic test_random_fill();
        wait_idle();
        reg_write(ADDR_LIMIT, 32'(LIMIT_MAX));
        quiet = 1'b1;
        run_random(180, 60, 15, 1);
        quiet = 1'b0;
    endtask

    task automatic test_random_mixed();
        wait_idle();
        reg_write(ADDR_LIMIT, 32'(LIMIT_RESET));
        run_random(200, 40, 25, 2);
    endtask

    task automatic test_random_tight_limit();
        wait_idle();
        reg_write(ADDR_LIMIT, 32'($urandom_range(1, 8)));
        run_random(150, 45, 30, 3);
    endtask

    // Receiver idles about a quarter of the cycles, except in quiet stretches.
    always @(posedge clk)
        rsp_stall <= !quiet && ($urandom_range(99) < 24);

    // Response checker: each accepted word against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("response with none pending", 64'(rsp), '0);
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 64'(rsp.status), 64'(want.status));
                if (rsp.hit !== want.hit)
                    report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
                if (rsp.mac_out !== want.mac_out)
                    report_mismatch("mac_out", 64'(rsp.mac_out), 64'(want.mac_out));
                if (rsp.count_out !== want.count_out)
                    report_mismatch("count_out", 64'(rsp.count_out), 64'(want.count_out));
            end
        end
    end

    // Cycles since the last word moved on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        @(posedge clk);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[neighbor_exact_match_table] ERROR");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;

        for (int i = 0; i < TABLE_DEPTH; i++)
            nb_used[i] = 1'b0;
        nb_count  = 0;
        cfg_limit = LIMIT_RESET;

        // Pool keys; some odd entries reuse the previous address under the
        // other family, so family mismatches show up in random traffic too.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_v6[i] = 1'($urandom_range(1));
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
            if (i % 2 == 1 && $urandom_range(3) == 0)
            begin
                pool_v6[i] = ~pool_v6[i-1];
                pool_hi[i] = pool_hi[i-1];
                pool_lo[i] = pool_lo[i-1];
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_entry_limit();
        test_random_fill();
        test_random_mixed();
        test_random_tight_limit();

        wait_idle();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (expected_rsp.size() != 0)
            report_mismatch("responses never returned", 64'(expected_rsp.size()), '0);
        if (errors == 0)
            $display("[neighbor_exact_match_table] OK");
        else
            $display("[neighbor_exact_match_table] ERROR");
        $finish;
    end

endmodule

### files.f
design/netm_pkg.sv
design/netm_cell.sv
design/netm_ctrl.sv
design/neighbor_exact_match_table.sv
design/netm_checker.sv
sim/neighbor_exact_match_table_test.sv
